>>> rtl/mqsb_pkg.sv
// Package for the multi-queue shared buffer.
// Holds the field widths, operation and status codes and the controller state type.
// No dependencies.
package mqsb_pkg;

	// Field widths of the request and the result.
	localparam int DATA_W = 32;
	localparam int QID_W  = 2;
	localparam int STAT_W = 2;

	// Number of queues that the queue_id field can address.
	localparam int QID_NUM = 1 << QID_W;

	// Operation carried in the request.
	typedef enum logic {
		OP_ENQUEUE = 1'b0,
		OP_DEQUEUE = 1'b1
	} op_t;

	// Result status.
	typedef enum logic [STAT_W-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_OVERFLOW  = 2'd1,
		STATUS_UNDERFLOW = 2'd2
	} status_t;

	// Data returned by a dequeue from an empty queue, and by every enqueue.
	localparam logic [DATA_W-1:0] DATA_UNDERFLOW = '1;
	localparam logic [DATA_W-1:0] DATA_NONE      = '0;

	// Controller states: request accepted and memories read, then write-back.
	typedef enum logic {
		ST_IDLE   = 1'b0,
		ST_UPDATE = 1'b1
	} state_t;

endpackage

>>> rtl/mqsb_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Used for the slot data store and the slot link store. No dependencies.
module mqsb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/multi_queue_shared_buffer.sv
// Top level of the multi-queue shared buffer: FIFO queues linked through one slot store.
// Depends on mqsb_pkg and mqsb_ram.
//
// Up to four FIFO queues share SLOT_COUNT data slots. Each slot has a link
// entry in a link memory; links chain every queue from head to tail and chain
// the free slots from the free-list head. In the accept state the link and data
// memories are read at the slot concerned; in the write-back state the links are
// written back and the result is loaded into the output register. The next
// request is taken once the previous one has been written back and its result
// has left or is leaving the output register. Slots that were never allocated are
// tracked by a fill count and read as linking to the next slot, so there is no
// clearing pass after reset. An enqueue with no free slot, or to a queue number
// of QUEUE_COUNT or more, reports overflow; a dequeue from an empty or nonexistent
// queue reports underflow with data -1. Neither changes any state.
module multi_queue_shared_buffer
	import mqsb_pkg::*;
#(
	parameter int SLOT_COUNT  = 16,
	parameter int QUEUE_COUNT = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// Request channel.
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic signed [DATA_W-1:0] s_tdata,  // [31:0] data_in
	input  logic [QID_W:0]           s_tuser,  // [0] op, [2:1] queue_id
	// Result channel.
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic signed [DATA_W-1:0] m_tdata,  // [31:0] data_out
	output logic [STAT_W-1:0]        m_tuser   // [1:0] status
);

	// Slot index and link widths; a link equal to SLOT_COUNT is null.
	localparam int SW = $clog2(SLOT_COUNT);
	localparam int NW = $clog2(SLOT_COUNT + 1);
	localparam logic [NW-1:0] NULL_SLOT = NW'(SLOT_COUNT);

	// Queues that actually exist and can be addressed.
	localparam int QDEPTH = (QUEUE_COUNT < QID_NUM) ? QUEUE_COUNT : QID_NUM;
	localparam int QIDX_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam logic [QID_W:0] QLIMIT = (QID_W + 1)'(QDEPTH);

	state_t state_q, state_d;

	// Queue and free-list pointers.
	logic [NW-1:0] head_q [QDEPTH];
	logic [NW-1:0] tail_q [QDEPTH];
	logic [NW-1:0] free_head_q;
	logic [NW-1:0] fill_q;

	// Request decode in the accept cycle.
	logic              accept;
	logic              upd;
	op_t               op_a;
	logic              enq_a;
	logic [QID_W-1:0]  qid_a;
	logic [QIDX_W-1:0] qi_a;
	logic              q_in_range;
	logic [NW-1:0]     head_a;
	logic [NW-1:0]     tail_a;
	logic              head_empty_a;
	logic              ok_a;
	logic [NW-1:0]     slot_a;
	logic              fresh_a;

	// Request held for the write-back cycle.
	op_t               op_s1;
	logic [QIDX_W-1:0] qi_s1;
	logic [DATA_W-1:0] data_s1;
	logic              ok_s1;
	logic [NW-1:0]     slot_s1;
	logic [NW-1:0]     tail_s1;
	logic              head_empty_s1;
	logic              fresh_s1;

	// Memory ports.
	logic              link_rd_en;
	logic [NW-1:0]     link_rdata;
	logic              link_wr_en;
	logic [SW-1:0]     link_wr_addr;
	logic [NW-1:0]     link_wdata;
	logic              data_rd_en;
	logic [DATA_W-1:0] data_rdata;
	logic              data_wr_en;

	// Write-back decisions.
	logic enq_ok;
	logic deq_ok;

	// Output register.
	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	status_t           out_status_q;

	// Controller state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Controller outputs: a request is taken only when the output register is
	// free by the time its result is loaded.
	always_comb begin
		s_tready = 1'b0;
		upd      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = !out_valid_q || m_tready;
			end
			ST_UPDATE: begin
				upd = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign accept = s_tvalid && s_tready;

	// Decode the request and pick the slot it works on.
	assign op_a         = op_t'(s_tuser[0]);
	assign enq_a        = (op_a == OP_ENQUEUE);
	assign qid_a        = s_tuser[QID_W:1];
	assign qi_a         = qid_a[QIDX_W-1:0];
	assign q_in_range   = {1'b0, qid_a} < QLIMIT;
	assign head_a       = head_q[qi_a];
	assign tail_a       = tail_q[qi_a];
	assign head_empty_a = !(head_a < NULL_SLOT);
	assign ok_a         = q_in_range && (enq_a ? (free_head_q < NULL_SLOT) : !head_empty_a);
	assign slot_a       = enq_a ? free_head_q : head_a;
	assign fresh_a      = free_head_q >= fill_q;

	// Read the link of the slot unless it was never allocated; read data on dequeue.
	assign link_rd_en = accept && ok_a && !(enq_a && fresh_a);
	assign data_rd_en = accept && ok_a && !enq_a;

	// Hold the request for the write-back cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1         <= op_a;
			qi_s1         <= qi_a;
			data_s1       <= s_tdata;
			ok_s1         <= ok_a;
			slot_s1       <= slot_a;
			tail_s1       <= tail_a;
			head_empty_s1 <= head_empty_a;
			fresh_s1      <= fresh_a;
		end
	end

	assign enq_ok = upd && ok_s1 && (op_s1 == OP_ENQUEUE);
	assign deq_ok = upd && ok_s1 && (op_s1 == OP_DEQUEUE);

	// Link write-back: an enqueue links the old tail to the new slot, a dequeue
	// pushes the freed slot onto the front of the free list.
	always_comb begin
		link_wr_en   = 1'b0;
		link_wr_addr = slot_s1[SW-1:0];
		link_wdata   = free_head_q;
		if (enq_ok && !head_empty_s1) begin
			link_wr_en   = 1'b1;
			link_wr_addr = tail_s1[SW-1:0];
			link_wdata   = slot_s1;
		end else if (deq_ok) begin
			link_wr_en = 1'b1;
		end
	end

	assign data_wr_en = enq_ok;

	// Pointer updates. A dequeue of the last entry is found by comparing its slot with
	// the tail and leaves the head null, since the tail slot's link is never written on enqueue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			fill_q      <= '0;
			for (int i = 0; i < QDEPTH; i++) begin
				head_q[i] <= NULL_SLOT;
				tail_q[i] <= NULL_SLOT;
			end
		end else begin
			if (enq_ok) begin
				free_head_q <= fresh_s1 ? (slot_s1 + 1'b1) : link_rdata;
				if (fresh_s1) begin
					fill_q <= fill_q + 1'b1;
				end
				if (head_empty_s1) begin
					head_q[qi_s1] <= slot_s1;
				end
				tail_q[qi_s1] <= slot_s1;
			end else if (deq_ok) begin
				free_head_q   <= slot_s1;
				head_q[qi_s1] <= (slot_s1 == tail_s1) ? NULL_SLOT : link_rdata;
			end
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (upd) begin
			if (deq_ok) begin
				out_data_q   <= data_rdata;
				out_status_q <= STATUS_OK;
			end else if (op_s1 == OP_DEQUEUE) begin
				out_data_q   <= DATA_UNDERFLOW;
				out_status_q <= STATUS_UNDERFLOW;
			end else begin
				out_data_q   <= DATA_NONE;
				out_status_q <= ok_s1 ? STATUS_OK : STATUS_OVERFLOW;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;

	// Slot link store.
	mqsb_ram #(
		.WIDTH (NW),
		.DEPTH (SLOT_COUNT)
	) u_link_ram (
		.clk     (clk),
		.wr_en   (link_wr_en),
		.wr_addr (link_wr_addr),
		.wr_data (link_wdata),
		.rd_en   (link_rd_en),
		.rd_addr (slot_a[SW-1:0]),
		.rd_data (link_rdata)
	);

	// Slot data store.
	mqsb_ram #(
		.WIDTH (DATA_W),
		.DEPTH (SLOT_COUNT)
	) u_data_ram (
		.clk     (clk),
		.wr_en   (data_wr_en),
		.wr_addr (slot_s1[SW-1:0]),
		.wr_data (data_s1),
		.rd_en   (data_rd_en),
		.rd_addr (slot_a[SW-1:0]),
		.rd_data (data_rdata)
	);

	// An accepted request has its result loaded into the output register by the write-back state.
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##2 m_tvalid)
		else $error("result not presented two cycles after request");

	// The output register is empty whenever a result is about to be loaded.
	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPDATE |-> !out_valid_q)
		else $error("result loaded over a pending result");

	// The free-list head is a slot or null.
	a_free_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q <= NULL_SLOT)
		else $error("free-list head out of range");

	// The fill count never passes the store size, and untouched slots sit at the
	// end of the free list.
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= NULL_SLOT && (free_head_q <= fill_q || free_head_q == NULL_SLOT))
		else $error("fill count inconsistent with free list");

endmodule

>>> verif/tb.sv
// Testbench for multi_queue_shared_buffer: directed and random enqueue/dequeue requests
// with random stalls on both streams, checked against a behavioral model of the queues.
// Depends on mqsb_pkg and the multi_queue_shared_buffer RTL.
module tb;
	import mqsb_pkg::*;

	localparam int SLOTS  = 16;
	localparam int QUEUES = 4;
	localparam int RANDOM_REQUESTS = 650;

	// One expected result of a request.
	typedef struct {
		logic [DATA_W-1:0] data;
		status_t           status;
	} result_t;

	// Behavioral copy of the shared buffer and the results it still owes.
	class mqsb_scoreboard;
		logic [DATA_W-1:0] slot_data[SLOTS];
		int                slot_link[SLOTS];
		int                queue_head[QUEUES];
		int                queue_tail[QUEUES];
		int                free_head;
		result_t           owed_results[$];
		int                errors;

		// Reset state: every queue empty, the free list chains all slots in order.
		function new();
			for (int i = 0; i < SLOTS; i++) begin
				slot_link[i] = i + 1;
			end
			for (int q = 0; q < QUEUES; q++) begin
				queue_head[q] = SLOTS;
				queue_tail[q] = SLOTS;
			end
			free_head = 0;
			errors = 0;
		endfunction

		// Applies one accepted request and queues the result it must produce.
		function void note_request(op_t op, int qid, logic [DATA_W-1:0] data_in);
			result_t r;
			int      slot;
			if (op == OP_ENQUEUE) begin
				r.data = DATA_NONE;
				if (qid >= QUEUES || free_head >= SLOTS) begin
					r.status = STATUS_OVERFLOW;
				end else begin
					slot = free_head;
					free_head = slot_link[slot];
					if (queue_head[qid] >= SLOTS) begin
						queue_head[qid] = slot;
					end else if (queue_tail[qid] < SLOTS) begin
						slot_link[queue_tail[qid]] = slot;
					end
					slot_link[slot] = SLOTS;
					queue_tail[qid] = slot;
					slot_data[slot] = data_in;
					r.status = STATUS_OK;
				end
			end else begin
				if (qid >= QUEUES || queue_head[qid] >= SLOTS) begin
					r.data = DATA_UNDERFLOW;
					r.status = STATUS_UNDERFLOW;
				end else begin
					// The emptied queue keeps its stale tail; the null head hides it.
					slot = queue_head[qid];
					queue_head[qid] = slot_link[slot];
					slot_link[slot] = free_head;
					free_head = slot;
					r.data = slot_data[slot];
					r.status = STATUS_OK;
				end
			end
			owed_results.push_back(r);
		endfunction

		// Compares one delivered result with the oldest owed one.
		function void check_result(logic [DATA_W-1:0] data, status_t status);
			result_t r;
			if (owed_results.size() == 0) begin
				$display("%0t: unexpected result data=%h status=%0d", $time, data, status);
				errors++;
			end else begin
				r = owed_results.pop_front();
				if (data !== r.data) begin
					$display("%0t: data_out expected %h actual %h", $time, r.data, data);
					errors++;
				end
				if (status !== r.status) begin
					$display("%0t: status expected %0d actual %0d", $time, r.status, status);
					errors++;
				end
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic signed [DATA_W-1:0] s_tdata;
	logic [QID_W:0]           s_tuser;
	logic                     m_tvalid;
	logic                     m_tready;
	logic signed [DATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]        m_tuser;

	mqsb_scoreboard sb = new();
	bit             steady_send;

	multi_queue_shared_buffer #(
		.SLOT_COUNT(SLOTS),
		.QUEUE_COUNT(QUEUES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	// Occasionally an extreme value, otherwise a random word.
	function automatic logic [DATA_W-1:0] pick_data();
		case ($urandom_range(19))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Presents one request after an optional idle gap and holds it until accepted.
	task automatic send_request(op_t op, logic [QID_W-1:0] qid, logic [DATA_W-1:0] data);
		int gap;
		gap = steady_send ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tuser <= {qid, op};
		do @(posedge clk); while (!s_tready);
		sb.note_request(op, qid, data);
	endtask

	// Result side: random stalls, with occasional long stretches of steady readiness.
	initial begin
		int run;
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			run = ($urandom_range(7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tdata, status_t'(m_tuser));
		end
	end

	// Stimulus and end of run.
	initial begin
		int               run_left;
		int               enq_pct;
		int               hot_queue;
		op_t              op;
		logic [QID_W-1:0] qid;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		steady_send = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: underflow on an empty queue, fill every slot with extreme values
		// spread over all queues, overflow, then drain one queue past empty.
		send_request(OP_DEQUEUE, 2'd0, 32'h0);
		for (int i = 0; i < SLOTS; i++) begin
			case (i % 4)
				0: send_request(OP_ENQUEUE, QID_W'(i % QUEUES), 32'h8000_0000 + i);
				1: send_request(OP_ENQUEUE, QID_W'(i % QUEUES), 32'h7FFF_FFFF - i);
				2: send_request(OP_ENQUEUE, QID_W'(i % QUEUES), 32'h0000_0000 + i);
				default: send_request(OP_ENQUEUE, QID_W'(i % QUEUES), 32'hFFFF_FFFF - i);
			endcase
		end
		send_request(OP_ENQUEUE, 2'd3, 32'h1234_5678);
		for (int i = 0; i < 5; i++) begin
			send_request(OP_DEQUEUE, 2'd1, 32'hFFFF_FFFF);
		end

		// Random: runs that lean toward filling, draining or a mix, often on one queue.
		run_left = 0;
		enq_pct = 50;
		hot_queue = 0;
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (run_left == 0) begin
				run_left = $urandom_range(8, 60);
				case ($urandom_range(2))
					0: enq_pct = 80;
					1: enq_pct = 20;
					default: enq_pct = 50;
				endcase
				hot_queue = $urandom_range(QUEUES - 1);
				steady_send = ($urandom_range(3) == 0);
			end
			run_left--;
			op = ($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
			qid = ($urandom_range(99) < 60) ? QID_W'(hot_queue) : QID_W'($urandom);
			send_request(op, qid, pick_data());
		end
		s_tvalid <= 1'b0;

		while (sb.owed_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.owed_results.size() == 0) begin
			$display("** multi_queue_shared_buffer: PASSED **");
		end else begin
			$display("** multi_queue_shared_buffer: FAILED **");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#5000000;
		$display("** multi_queue_shared_buffer: FAILED **");
		$finish;
	end

endmodule
